// ----- sv/nalsplit_pkg.sv -----
// Shared types and constants for the Annex B NAL unit splitter.
`timescale 1ns / 1ps
`default_nettype none
package nalsplit_pkg;

  localparam logic [4:0]  TYPE_MASK   = 5'h1F;
  localparam logic [31:0] STEP_RESET  = 32'd90000;
  localparam logic [7:0]  CODE_ZERO   = 8'h00;
  localparam logic [7:0]  CODE_ONE    = 8'h01;
  localparam logic [31:0] COUNT_MAX   = 32'hFFFF_FFFF;
  localparam logic [47:0] TS_MAX      = 48'hFFFF_FFFF_FFFF;

  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = 3;
  localparam int FIFO_CW    = 4;

  typedef struct packed {
    logic [31:0] nal_offset;
    logic [31:0] nal_length;
    logic [4:0]  nal_type;
    logic        type_valid;
    logic [31:0] nal_index;
    logic        last_record;
  } rec_t;

  typedef struct packed {
    rec_t        rec;
    logic [47:0] timestamp;
  } out_rec_t;

endpackage
`default_nettype wire

// ----- sv/annexb_nal_unit_splitter.sv -----
// Annex B start code scanner that emits one record per NAL unit.
//
// Usage: bytes of one buffer enter on the in_ channel (in_valid / in_stall),
// in_end_of_buffer set on the final byte. Each NAL unit gives one record on
// the out_ channel (out_valid / out_stall): offset and length of the unit
// including its start code, header type, ordinal and timestamp. A record
// leaves when the following start code is confirmed or the buffer ends;
// a start code confirmed on the final byte gives two records in a row.
// The cfg_ channel writes time_step; cfg_ready is always high.
// Throughput: one byte per cycle while in_stall is low. The scan state
// updates in the cycle of acceptance; records pass a record register and a
// multiplier register (index times time_step) into an eight-entry output
// queue, from which the oldest record is shown on the out_ ports. in_stall
// rises when the queue plus records in flight leave fewer than two free
// slots, which happens only while the receiver stalls. Reset clears the
// scan state and the queue and loads time_step with 90000. A held record
// keeps its payload until taken.
`timescale 1ns / 1ps
`default_nettype none
module annexb_nal_unit_splitter #(
  parameter int OFFSET_BITS = 32
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [7:0]  in_data_byte,
  input  wire         in_end_of_buffer,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [31:0] out_nal_offset,
  output logic [31:0] out_nal_length,
  output logic [4:0]  out_nal_type,
  output logic        out_type_valid,
  output logic [31:0] out_nal_index,
  output logic [47:0] out_timestamp,
  output logic        out_last_record,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [31:0] cfg_time_step
);
  import nalsplit_pkg::*;

  localparam logic [OFFSET_BITS-1:0] POS_MAX = {OFFSET_BITS{1'b1}};
  localparam logic [OFFSET_BITS-1:0] POS_ONE = OFFSET_BITS'(1);
  localparam logic [OFFSET_BITS-1:0] POS_THREE = OFFSET_BITS'(3);
  localparam logic [OFFSET_BITS-1:0] POS_FOUR = OFFSET_BITS'(4);

  logic [31:0]            step_r;
  logic [7:0]             win_r [3];
  logic [OFFSET_BITS-1:0] pos_r;
  logic                   open_r;
  logic [OFFSET_BITS-1:0] start_r;
  logic [4:0]             htype_r;
  logic                   hcap_r;
  logic [OFFSET_BITS-1:0] resume_r;
  logic [31:0]            count_r;

  logic [OFFSET_BITS-1:0] pos_nxt, start_nxt, resume_nxt;
  logic                   open_nxt, hcap_nxt;
  logic [4:0]             htype_nxt;
  logic [31:0]            count_nxt;
  logic                   emit_a, emit_b;
  rec_t                   rec_a, rec_b;

  logic                   a1_v_r, b1_v_r, a2_v_r, b2_v_r;
  rec_t                   a1_rec_r, b1_rec_r, a2_rec_r, b2_rec_r;
  logic [63:0]            a2_prod_r, b2_prod_r;

  out_rec_t               fifo_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]     wptr_r, rptr_r;
  logic [FIFO_CW-1:0]     cnt_r;
  logic [FIFO_CW-1:0]     inflight;
  logic [FIFO_AW-1:0]     wptr_b;
  out_rec_t               ent_a, ent_b;
  logic                   in_acc, out_acc;

  function automatic logic [31:0] count_inc(input logic [31:0] c);
    return (c == COUNT_MAX) ? c : c + 32'd1;
  endfunction

  function automatic logic [47:0] ts_sat(input logic [63:0] p);
    return (p[63:48] != 16'd0) ? TS_MAX : p[47:0];
  endfunction

  assign in_acc    = in_valid && !in_stall;
  assign out_acc   = out_valid && !out_stall;
  assign cfg_ready = 1'b1;

  always_comb begin
    logic [OFFSET_BITS-1:0] p;
    logic                   three, four, hit;
    logic [4:0]             t1;
    logic                   c1;
    logic [31:0]            cnt1;
    p         = pos_r - POS_THREE;
    t1        = htype_r;
    c1        = hcap_r;
    if (open_r && !hcap_r) begin
      t1 = in_data_byte[4:0] & TYPE_MASK;
      c1 = 1'b1;
    end
    three     = win_r[2] == CODE_ONE;
    four      = (win_r[2] == CODE_ZERO) && (in_data_byte == CODE_ONE);
    hit       = (pos_r >= POS_THREE) && (pos_r != POS_MAX) && (p >= resume_r) &&
                (win_r[0] == CODE_ZERO) && (win_r[1] == CODE_ZERO) && (three || four);
    emit_a    = hit && open_r;
    rec_a.nal_offset  = 32'(start_r);
    rec_a.nal_length  = 32'(p - start_r);
    rec_a.nal_type    = c1 ? t1 : 5'd0;
    rec_a.type_valid  = c1;
    rec_a.nal_index   = count_r;
    rec_a.last_record = 1'b0;
    cnt1      = emit_a ? count_inc(count_r) : count_r;
    open_nxt  = open_r;
    start_nxt = start_r;
    resume_nxt = resume_r;
    htype_nxt = t1;
    hcap_nxt  = c1;
    if (hit) begin
      open_nxt   = 1'b1;
      start_nxt  = p;
      resume_nxt = p + POS_FOUR;
      htype_nxt  = three ? (in_data_byte[4:0] & TYPE_MASK) : 5'd0;
      hcap_nxt   = three;
    end
    pos_nxt   = (pos_r == POS_MAX) ? pos_r : pos_r + POS_ONE;
    count_nxt = cnt1;
    emit_b    = in_end_of_buffer && open_nxt;
    rec_b.nal_offset  = 32'(start_nxt);
    rec_b.nal_length  = 32'(pos_nxt - start_nxt);
    rec_b.nal_type    = hcap_nxt ? htype_nxt : 5'd0;
    rec_b.type_valid  = hcap_nxt;
    rec_b.nal_index   = cnt1;
    rec_b.last_record = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r   <= STEP_RESET;
      win_r[0] <= CODE_ZERO;
      win_r[1] <= CODE_ZERO;
      win_r[2] <= CODE_ZERO;
      pos_r    <= '0;
      open_r   <= 1'b0;
      start_r  <= '0;
      htype_r  <= 5'd0;
      hcap_r   <= 1'b0;
      resume_r <= '0;
      count_r  <= 32'd0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        step_r <= cfg_time_step;
      end
      if (in_acc) begin
        if (in_end_of_buffer) begin
          win_r[0] <= CODE_ZERO;
          win_r[1] <= CODE_ZERO;
          win_r[2] <= CODE_ZERO;
          pos_r    <= '0;
          open_r   <= 1'b0;
          start_r  <= '0;
          htype_r  <= 5'd0;
          hcap_r   <= 1'b0;
          resume_r <= '0;
          count_r  <= 32'd0;
        end else begin
          win_r[0] <= win_r[1];
          win_r[1] <= win_r[2];
          win_r[2] <= in_data_byte;
          pos_r    <= pos_nxt;
          open_r   <= open_nxt;
          start_r  <= start_nxt;
          htype_r  <= htype_nxt;
          hcap_r   <= hcap_nxt;
          resume_r <= resume_nxt;
          count_r  <= count_nxt;
        end
      end
    end
  end

  // record and multiplier stages advance every cycle; space is reserved at accept
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a1_v_r <= 1'b0;
      b1_v_r <= 1'b0;
      a2_v_r <= 1'b0;
      b2_v_r <= 1'b0;
    end else begin
      a1_v_r <= in_acc && emit_a;
      b1_v_r <= in_acc && emit_b;
      a2_v_r <= a1_v_r;
      b2_v_r <= b1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    a1_rec_r  <= rec_a;
    b1_rec_r  <= rec_b;
    a2_rec_r  <= a1_rec_r;
    b2_rec_r  <= b1_rec_r;
    a2_prod_r <= 64'(a1_rec_r.nal_index) * 64'(step_r);
    b2_prod_r <= 64'(b1_rec_r.nal_index) * 64'(step_r);
  end

  always_comb begin
    ent_a.rec       = a2_rec_r;
    ent_a.timestamp = ts_sat(a2_prod_r);
    ent_b.rec       = b2_rec_r;
    ent_b.timestamp = ts_sat(b2_prod_r);
    wptr_b          = a2_v_r ? wptr_r + FIFO_AW'(1) : wptr_r;
    inflight        = FIFO_CW'(a1_v_r) + FIFO_CW'(b1_v_r) +
                      FIFO_CW'(a2_v_r) + FIFO_CW'(b2_v_r);
    in_stall        = (cnt_r + inflight) > FIFO_CW'(FIFO_DEPTH - 2);
  end

  always_ff @(posedge clk) begin
    if (a2_v_r) begin
      fifo_r[wptr_r] <= ent_a;
    end
    if (b2_v_r) begin
      fifo_r[wptr_b] <= ent_b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_r + FIFO_AW'(a2_v_r) + FIFO_AW'(b2_v_r);
      rptr_r <= rptr_r + FIFO_AW'(out_acc);
      cnt_r  <= cnt_r + FIFO_CW'(a2_v_r) + FIFO_CW'(b2_v_r) - FIFO_CW'(out_acc);
    end
  end

  always_comb begin
    out_valid       = cnt_r != '0;
    out_nal_offset  = fifo_r[rptr_r].rec.nal_offset;
    out_nal_length  = fifo_r[rptr_r].rec.nal_length;
    out_nal_type    = fifo_r[rptr_r].rec.nal_type;
    out_type_valid  = fifo_r[rptr_r].rec.type_valid;
    out_nal_index   = fifo_r[rptr_r].rec.nal_index;
    out_timestamp   = fifo_r[rptr_r].timestamp;
    out_last_record = fifo_r[rptr_r].rec.last_record;
  end

endmodule
`default_nettype wire

// ----- sv/annexb_nal_unit_splitter_chk.sv -----
// Port-level checks for the NAL unit splitter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module nalsplit_chk (
  input wire        clk,
  input wire        rst_n,
  input wire        out_valid,
  input wire        out_stall,
  input wire [31:0] out_nal_offset,
  input wire [4:0]  out_nal_type,
  input wire        out_type_valid,
  input wire [31:0] out_nal_index,
  input wire [47:0] out_timestamp
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("request shown right after reset");

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("stalled request dropped");

  a_hold_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_nal_offset) && $stable(out_nal_index))
    else $error("stalled request changed");

  a_type_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_type_valid |-> out_nal_type == 5'd0)
    else $error("type reported without header byte");

  a_first_ts: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_nal_index == 32'd0 |-> out_timestamp == 48'd0)
    else $error("first unit timestamp not zero");

endmodule

bind annexb_nal_unit_splitter nalsplit_chk u_nalsplit_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_nal_offset (out_nal_offset),
  .out_nal_type   (out_nal_type),
  .out_type_valid (out_type_valid),
  .out_nal_index  (out_nal_index),
  .out_timestamp  (out_timestamp)
);
`default_nettype wire

// ----- sim/annexb_nal_unit_splitter_test.sv -----
// Self-checking testbench for the Annex B NAL unit splitter.
`timescale 1ns / 1ps
module annexb_nal_unit_splitter_test;
  import nalsplit_pkg::*;

  localparam int          LIMIT   = 300000;
  localparam int          SETTLE  = 8;
  localparam logic [63:0] POS_MAX = 64'hFFFF_FFFF;

  typedef struct {
    logic [7:0] data;
    logic       eob;
  } byte_req_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_end_of_buffer = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_nal_offset;
  logic [31:0] out_nal_length;
  logic [4:0]  out_nal_type;
  logic        out_type_valid;
  logic [31:0] out_nal_index;
  logic [47:0] out_timestamp;
  logic        out_last_record;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_time_step = 32'd0;

  byte_req_t feed_q[$];
  out_rec_t  records_due[$];
  int        errors = 0;
  int        cycle_count = 0;
  int        burst_left = 0;
  int        gap_left = 0;
  int        stall_mode = 0;
  int        stall_left = 0;

  logic [7:0]  win [0:2];
  logic [63:0] pos;
  logic        unit_live;
  logic [63:0] ustart;
  logic [4:0]  utype;
  logic        hdr_ok;
  logic [63:0] resume_at;
  logic [31:0] ucount;
  logic [31:0] step_now = STEP_RESET;

  annexb_nal_unit_splitter dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .in_end_of_buffer (in_end_of_buffer),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_nal_offset   (out_nal_offset),
    .out_nal_length   (out_nal_length),
    .out_nal_type     (out_nal_type),
    .out_type_valid   (out_type_valid),
    .out_nal_index    (out_nal_index),
    .out_timestamp    (out_timestamp),
    .out_last_record  (out_last_record),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_time_step    (cfg_time_step)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task clear_scanner;
    win[0] = CODE_ZERO;
    win[1] = CODE_ZERO;
    win[2] = CODE_ZERO;
    pos = 64'd0;
    unit_live = 1'b0;
    ustart = 64'd0;
    utype = 5'd0;
    hdr_ok = 1'b0;
    resume_at = 64'd0;
    ucount = 32'd0;
  endtask

  task close_unit(input logic [63:0] len, input logic last);
    out_rec_t    r;
    logic [63:0] prod;
    prod = {32'd0, ucount} * {32'd0, step_now};
    r.rec.nal_offset = ustart[31:0];
    r.rec.nal_length = len[31:0];
    r.rec.nal_type = hdr_ok ? (utype & TYPE_MASK) : 5'd0;
    r.rec.type_valid = hdr_ok;
    r.rec.nal_index = ucount;
    r.rec.last_record = last;
    r.timestamp = (prod > {16'd0, TS_MAX}) ? TS_MAX : prod[47:0];
    records_due.push_back(r);
    if (ucount != COUNT_MAX) ucount++;
  endtask

  task advance_scanner(input logic [7:0] b, input logic eob);
    logic [63:0] q;
    logic [63:0] p;
    logic        three;
    logic        four;
    q = pos;
    if (unit_live && !hdr_ok) begin
      utype = b[4:0] & TYPE_MASK;
      hdr_ok = 1'b1;
    end
    if (q >= 64'd3 && q < POS_MAX && (q - 64'd3) >= resume_at) begin
      p = q - 64'd3;
      three = (win[2] == CODE_ONE);
      four = (win[2] == CODE_ZERO) && (b == CODE_ONE);
      if (win[0] == CODE_ZERO && win[1] == CODE_ZERO && (three || four)) begin
        if (unit_live) close_unit(p - ustart, 1'b0);
        unit_live = 1'b1;
        ustart = p;
        resume_at = p + 64'd4;
        if (three) begin
          utype = b[4:0] & TYPE_MASK;
          hdr_ok = 1'b1;
        end else begin
          utype = 5'd0;
          hdr_ok = 1'b0;
        end
      end
    end
    win[0] = win[1];
    win[1] = win[2];
    win[2] = b;
    if (pos < POS_MAX) pos++;
    if (eob) begin
      if (unit_live) close_unit(pos - ustart, 1'b1);
      clear_scanner();
    end
  endtask

  // sender: bursts and gaps, hold a stalled request
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        advance_scanner(in_data_byte, in_end_of_buffer);
        void'(feed_q.pop_front());
      end
      if (!(in_valid && in_stall)) begin
        if (gap_left > 0 || feed_q.size() == 0) begin
          in_valid <= 1'b0;
          if (gap_left > 0) gap_left--;
        end else begin
          in_valid <= 1'b1;
          in_data_byte <= feed_q[0].data;
          in_end_of_buffer <= feed_q[0].eob;
          if (burst_left > 0) begin
            burst_left--;
          end else if ($urandom_range(0, 7) == 0) begin
            burst_left = $urandom_range(100, 250);
            gap_left = 0;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 4);
      stall_left = $urandom_range(16, 80);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      3: out_stall <= stall_left[2];
      default: out_stall <= 1'b1;
    endcase
  end

  task check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    out_rec_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (records_due.size() == 0) begin
        $display("%0t: unexpected record, expected none got offset %0h", $time,
                 out_nal_offset);
        errors++;
      end else begin
        want = records_due.pop_front();
        check_field("nal_offset", want.rec.nal_offset, out_nal_offset);
        check_field("nal_length", want.rec.nal_length, out_nal_length);
        check_field("nal_type", want.rec.nal_type, out_nal_type);
        check_field("type_valid", want.rec.type_valid, out_type_valid);
        check_field("nal_index", want.rec.nal_index, out_nal_index);
        check_field("timestamp", want.timestamp, out_timestamp);
        check_field("last_record", want.rec.last_record, out_last_record);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT) begin
      $display("annexb_nal_unit_splitter_test failed");
      $finish;
    end
  end

  task push_buffer(input logic [7:0] bytes[$]);
    byte_req_t r;
    for (int i = 0; i < bytes.size(); i++) begin
      r.data = bytes[i];
      r.eob = (i == bytes.size() - 1);
      feed_q.push_back(r);
    end
  endtask

  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return CODE_ZERO;
    if (r == 1) return CODE_ONE;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic add_buffer(output int count);
    logic [7:0] buf_q[$];
    int         n_units;
    int         plen;
    if ($urandom_range(0, 9) < 8) begin
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 4)) buf_q.push_back(pick_byte());
      n_units = $urandom_range(1, 6);
      for (int u = 0; u < n_units; u++) begin
        if ($urandom_range(0, 1) == 1) buf_q.push_back(CODE_ZERO);
        buf_q.push_back(CODE_ZERO);
        buf_q.push_back(CODE_ZERO);
        buf_q.push_back(CODE_ONE);
        if (u == n_units - 1 && $urandom_range(0, 5) == 0) break;
        buf_q.push_back(8'($urandom_range(0, 255)));
        plen = ($urandom_range(0, 15) == 0) ? $urandom_range(100, 300) : $urandom_range(0, 20);
        repeat (plen) buf_q.push_back(pick_byte());
      end
    end else begin
      repeat ($urandom_range(1, 40))
        buf_q.push_back(($urandom_range(0, 1) == 0) ? CODE_ZERO : pick_byte());
    end
    push_buffer(buf_q);
    count = buf_q.size();
  endtask

  task add_random(input int n);
    int made;
    int got;
    made = 0;
    while (made < n) begin
      add_buffer(got);
      made += got;
    end
  endtask

  task wait_drained;
    do @(negedge clk); while (feed_q.size() != 0 || in_valid || records_due.size() != 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  task write_step(input logic [31:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_time_step <= value;
    do @(posedge clk); while (!cfg_ready);
    step_now = value;
    cfg_valid <= 1'b0;
  endtask

  initial begin
    clear_scanner();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // leading junk, then a four-byte code confirmed on the final byte
    push_buffer('{8'hFF, 8'h00, 8'h00, 8'h01, 8'hE5, 8'h00, 8'h00, 8'h00, 8'h01});
    push_buffer('{8'h00, 8'h00, 8'h01, 8'hFF});
    // second code falls inside the skipped window
    push_buffer('{8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h01, 8'h07});
    push_buffer('{8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h01, 8'h1C});
    push_buffer('{8'h01});
    push_buffer('{8'h00, 8'h00, 8'h01});
    wait_drained();

    write_step(32'hFFFF_FFFF);
    add_random(160);
    wait_drained();
    write_step(32'd0);
    add_random(120);
    wait_drained();
    write_step(32'd1);
    add_random(120);
    wait_drained();
    write_step(STEP_RESET);
    add_random(90);
    wait_drained();
    write_step(32'($urandom));
    add_random(80);
    wait_drained();
    add_random(70);
    wait_drained();

    if (errors == 0 && records_due.size() == 0) begin
      $display("annexb_nal_unit_splitter_test passed");
    end else begin
      $display("annexb_nal_unit_splitter_test failed");
    end
    $finish;
  end

endmodule
